[sv/akf_pkg.sv]
// Shared types, constants and the update program of the altitude Kalman filter.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package akf_pkg;

   localparam int FRAC_BITS = 16;

   // Field widths of the channels and the register port.
   localparam int ACCEL_W    = 25;
   localparam int MM_W       = 16;
   localparam int TILT_W     = 17;
   localparam int STATE_W    = 32;
   localparam int MEAS_W     = 24;
   localparam int STEP_W     = 17;
   localparam int NOISE_W    = 21;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 21;

   // Working widths of the sequencer.
   localparam int WORD_W    = 34;                 // scratch word
   localparam int DIVD_W    = WORD_W + FRAC_BITS; // scaled dividend
   localparam int RES_W     = 50;                 // serial unit result
   localparam int ACC_W     = 51;                 // accumulator
   localparam int CNT_W     = 6;
   localparam int MUL_STEPS = WORD_W;
   localparam int DIV_STEPS = DIVD_W;
   localparam int PC_W      = 6;
   localparam int MEM_AW    = 4;

   localparam logic [STEP_W-1:0]  STEP_RST    = STEP_W'(655);
   localparam logic [NOISE_W-1:0] VNOISE_RST  = NOISE_W'(9359);
   localparam logic [NOISE_W-1:0] BNOISE_RST  = NOISE_W'(6554);
   localparam logic [NOISE_W-1:0] RNOISE_RST  = NOISE_W'(16384);
   localparam logic [NOISE_W-1:0] GRAVITY_RST = NOISE_W'(642690);
   localparam logic [WORD_W-1:0]  MM_PER_M    = WORD_W'(1000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_TIME = 3'd0,
      CSR_VEL_NOISE = 3'd1,
      CSR_BIAS_NOISE = 3'd2,
      CSR_RANGE_NOISE = 3'd3,
      CSR_GRAVITY = 3'd4
   } csr_type;

   // Operand codes: the first sixteen are scratch memory slots.
   typedef enum logic [4:0] {
      SRC_X0 = 5'd0, SRC_X1 = 5'd1, SRC_X2 = 5'd2,
      SRC_P00 = 5'd3, SRC_P01 = 5'd4, SRC_P02 = 5'd5,
      SRC_P11 = 5'd6, SRC_P12 = 5'd7, SRC_P22 = 5'd8,
      SRC_T = 5'd9, SRC_U = 5'd10, SRC_Y = 5'd11, SRC_Z = 5'd12,
      SRC_L0 = 5'd13, SRC_L1 = 5'd14, SRC_L2 = 5'd15,
      SRC_ZERO = 5'd16, SRC_ONE = 5'd17, SRC_HALF = 5'd18, SRC_DT = 5'd19,
      SRC_VN = 5'd20, SRC_BN = 5'd21, SRC_RN = 5'd22, SRC_G = 5'd23,
      SRC_ACC = 5'd24, SRC_MM = 5'd25, SRC_TC = 5'd26, SRC_K1000 = 5'd27
   } src_type;

   typedef enum logic {OP_MUL = 1'b0, OP_DIV = 1'b1} op_type;

   typedef enum logic [1:0] {
      WM_NONE = 2'd0, WM_SAT32 = 2'd1, WM_SAT25 = 2'd2, WM_RAW = 2'd3
   } wmode_type;

   typedef enum logic [1:0] {
      BR_NONE = 2'd0, BR_NOVALID = 2'd1, BR_NOPOS = 2'd2, BR_END = 2'd3
   } br_type;

   typedef struct packed {
      op_type    op;
      src_type   a_sel;
      src_type   b_sel;
      src_type   c_sel;
      logic      chain;
      logic      neg;
      wmode_type wmode;
      src_type   dst;
      br_type    br;
   } instr_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } akf_ctl_type;

   function automatic instr_type mk(input op_type op, input src_type a, input src_type b,
                                    input src_type c, input logic chain, input logic neg,
                                    input wmode_type wm, input src_type dst,
                                    input br_type br);
      instr_type r;
      r.op    = op;
      r.a_sel = a;
      r.b_sel = b;
      r.c_sel = c;
      r.chain = chain;
      r.neg   = neg;
      r.wmode = wm;
      r.dst   = dst;
      r.br    = br;
      return r;
   endfunction

   // dst = sat(base +/- a*b) for multiply steps, dst = sat(a*2^F / b) for divides.
   function automatic instr_type prog_rom(input logic [PC_W-1:0] pc);
      instr_type r;
      case (pc)
         6'd0:  r = mk(OP_MUL, SRC_DT, SRC_DT, SRC_ZERO, 1'b0, 1'b0, WM_SAT32, SRC_T, BR_NONE);
         6'd1:  r = mk(OP_MUL, SRC_T, SRC_HALF, SRC_ZERO, 1'b0, 1'b0, WM_SAT32, SRC_T, BR_NONE);
         6'd2:  r = mk(OP_MUL, SRC_ACC, SRC_ONE, SRC_ZERO, 1'b0, 1'b1, WM_NONE, SRC_U, BR_NONE);
         6'd3:  r = mk(OP_MUL, SRC_G, SRC_ONE, SRC_ZERO, 1'b1, 1'b1, WM_SAT25, SRC_U, BR_NONE);
         6'd4:  r = mk(OP_MUL, SRC_DT, SRC_X1, SRC_X0, 1'b0, 1'b0, WM_NONE, SRC_X0, BR_NONE);
         6'd5:  r = mk(OP_MUL, SRC_T, SRC_U, SRC_X0, 1'b1, 1'b1, WM_SAT32, SRC_X0, BR_NONE);
         6'd6:  r = mk(OP_MUL, SRC_DT, SRC_X2, SRC_X1, 1'b0, 1'b1, WM_NONE, SRC_X1, BR_NONE);
         6'd7:  r = mk(OP_MUL, SRC_DT, SRC_U, SRC_X1, 1'b1, 1'b1, WM_SAT32, SRC_X1, BR_NONE);
         6'd8:  r = mk(OP_MUL, SRC_DT, SRC_P01, SRC_P00, 1'b0, 1'b0, WM_SAT32, SRC_P00, BR_NONE);
         6'd9:  r = mk(OP_MUL, SRC_DT, SRC_P11, SRC_P01, 1'b0, 1'b0, WM_SAT32, SRC_P01, BR_NONE);
         6'd10: r = mk(OP_MUL, SRC_DT, SRC_P12, SRC_P02, 1'b0, 1'b0, WM_SAT32, SRC_P02, BR_NONE);
         6'd11: r = mk(OP_MUL, SRC_DT, SRC_P12, SRC_P11, 1'b0, 1'b1, WM_SAT32, SRC_P11, BR_NONE);
         6'd12: r = mk(OP_MUL, SRC_DT, SRC_P22, SRC_P12, 1'b0, 1'b1, WM_SAT32, SRC_P12, BR_NONE);
         6'd13: r = mk(OP_MUL, SRC_DT, SRC_P01, SRC_P00, 1'b0, 1'b0, WM_SAT32, SRC_P00, BR_NONE);
         6'd14: r = mk(OP_MUL, SRC_DT, SRC_P02, SRC_P01, 1'b0, 1'b1, WM_SAT32, SRC_P01, BR_NONE);
         6'd15: r = mk(OP_MUL, SRC_DT, SRC_P12, SRC_P11, 1'b0, 1'b1, WM_NONE, SRC_P11, BR_NONE);
         6'd16: r = mk(OP_MUL, SRC_VN, SRC_ONE, SRC_P11, 1'b1, 1'b0, WM_SAT32, SRC_P11, BR_NONE);
         6'd17: r = mk(OP_MUL, SRC_BN, SRC_ONE, SRC_P22, 1'b0, 1'b0, WM_SAT32, SRC_P22,
                       BR_NOVALID);
         6'd18: r = mk(OP_DIV, SRC_MM, SRC_K1000, SRC_ZERO, 1'b0, 1'b0, WM_SAT32, SRC_T, BR_NONE);
         6'd19: r = mk(OP_MUL, SRC_T, SRC_TC, SRC_ZERO, 1'b0, 1'b1, WM_SAT32, SRC_Y, BR_NONE);
         6'd20: r = mk(OP_MUL, SRC_RN, SRC_ONE, SRC_P00, 1'b0, 1'b0, WM_RAW, SRC_T, BR_NOPOS);
         6'd21: r = mk(OP_DIV, SRC_P00, SRC_T, SRC_ZERO, 1'b0, 1'b0, WM_SAT32, SRC_L0, BR_NONE);
         6'd22: r = mk(OP_DIV, SRC_P01, SRC_T, SRC_ZERO, 1'b0, 1'b0, WM_SAT32, SRC_L1, BR_NONE);
         6'd23: r = mk(OP_DIV, SRC_P02, SRC_T, SRC_ZERO, 1'b0, 1'b0, WM_SAT32, SRC_L2, BR_NONE);
         6'd24: r = mk(OP_MUL, SRC_X0, SRC_ONE, SRC_Y, 1'b0, 1'b1, WM_SAT32, SRC_Z, BR_NONE);
         6'd25: r = mk(OP_MUL, SRC_L0, SRC_Z, SRC_X0, 1'b0, 1'b0, WM_SAT32, SRC_X0, BR_NONE);
         6'd26: r = mk(OP_MUL, SRC_L1, SRC_Z, SRC_X1, 1'b0, 1'b0, WM_SAT32, SRC_X1, BR_NONE);
         6'd27: r = mk(OP_MUL, SRC_L2, SRC_Z, SRC_X2, 1'b0, 1'b0, WM_SAT32, SRC_X2, BR_NONE);
         6'd28: r = mk(OP_MUL, SRC_L2, SRC_P02, SRC_P22, 1'b0, 1'b1, WM_SAT32, SRC_P22, BR_NONE);
         6'd29: r = mk(OP_MUL, SRC_L1, SRC_P02, SRC_P12, 1'b0, 1'b1, WM_SAT32, SRC_P12, BR_NONE);
         6'd30: r = mk(OP_MUL, SRC_L1, SRC_P01, SRC_P11, 1'b0, 1'b1, WM_SAT32, SRC_P11, BR_NONE);
         6'd31: r = mk(OP_MUL, SRC_L0, SRC_P00, SRC_P00, 1'b0, 1'b1, WM_SAT32, SRC_P00, BR_NONE);
         6'd32: r = mk(OP_MUL, SRC_L0, SRC_P01, SRC_P01, 1'b0, 1'b1, WM_SAT32, SRC_P01, BR_NONE);
         6'd33: r = mk(OP_MUL, SRC_L0, SRC_P02, SRC_P02, 1'b0, 1'b1, WM_SAT32, SRC_P02, BR_END);
         default: r = mk(OP_MUL, SRC_ZERO, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, WM_NONE, SRC_X0,
                         BR_END);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/akf_req_if.sv]
// Input channel of the altitude Kalman filter: one sensor tick per transfer.
// Depends on akf_pkg for the field widths.
`default_nettype none

interface akf_req_if import akf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [ACCEL_W-1:0] vertical_accel;
   logic                      range_valid;
   logic [MM_W-1:0]           range_mm;
   logic [TILT_W-1:0]         tilt_cosine;

   modport source(output valid, vertical_accel, range_valid, range_mm, tilt_cosine,
                  input ready);
   modport sink(input valid, vertical_accel, range_valid, range_mm, tilt_cosine,
                output ready);
endinterface

`default_nettype wire

[sv/akf_rsp_if.sv]
// Result channel of the altitude Kalman filter: one estimate per transfer.
// Depends on akf_pkg for the field widths.
`default_nettype none

interface akf_rsp_if import akf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [STATE_W-1:0] altitude;
   logic signed [STATE_W-1:0] vertical_velocity;
   logic signed [STATE_W-1:0] accel_bias;
   logic signed [MEAS_W-1:0]  measured_altitude;
   logic signed [ACCEL_W-1:0] net_accel;
   logic                      corrected;
   logic                      saturated;

   modport source(output valid, altitude, vertical_velocity, accel_bias, measured_altitude,
                  net_accel, corrected, saturated, input ready);
   modport sink(input valid, altitude, vertical_velocity, accel_bias, measured_altitude,
                net_accel, corrected, saturated, output ready);
endinterface

`default_nettype wire

[sv/akf_serial_unit.sv]
// Bit-serial multiplier (floor of product over 2^F) and restoring divider
// (truncated a*2^F / |b|). Depends on akf_pkg.
`default_nettype none

module akf_serial_unit import akf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  akf_ctl_type              ctl,
   input  logic signed [WORD_W-1:0] opa,
   input  logic signed [WORD_W-1:0] opb,
   output logic                     done,
   output logic signed [RES_W-1:0]  result
);

   logic                    busy_ff, post_ff, done_ff, div_ff, neg_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [WORD_W-1:0]       dvs_ff;
   logic [WORD_W:0]         hi_ff;
   logic [DIVD_W-1:0]       lo_ff;
   logic signed [RES_W-1:0] result_ff;

   logic [WORD_W-1:0]         amag, bmag;
   logic [WORD_W+1:0]         msum;
   logic [WORD_W:0]           dtry;
   logic                      dge;
   logic [2*WORD_W:0]         prod;
   logic signed [2*WORD_W+1:0] prod_s;
   logic signed [DIVD_W:0]    quot_s;
   logic [CNT_W-1:0]          last;

   always_comb begin
      amag   = opa[WORD_W-1] ? WORD_W'(-opa) : WORD_W'(opa);
      bmag   = opb[WORD_W-1] ? WORD_W'(-opb) : WORD_W'(opb);
      msum   = {1'b0, hi_ff} + (lo_ff[0] ? (WORD_W+2)'(dvs_ff) : '0);
      dtry   = {hi_ff[WORD_W-1:0], lo_ff[DIVD_W-1]};
      dge    = dtry >= {1'b0, dvs_ff};
      prod   = {hi_ff, lo_ff[WORD_W-1:0]};
      prod_s = $signed({1'b0, prod});
      if (neg_ff) begin
         prod_s = -prod_s;
      end
      quot_s = $signed({1'b0, lo_ff});
      if (neg_ff) begin
         quot_s = -quot_s;
      end
      last = div_ff ? CNT_W'(DIV_STEPS - 1) : CNT_W'(MUL_STEPS - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         post_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            div_ff  <= ctl.is_div;
            hi_ff   <= '0;
            if (ctl.is_div) begin
               neg_ff <= opa[WORD_W-1];
               dvs_ff <= bmag;
               lo_ff  <= {amag, {FRAC_BITS{1'b0}}};
            end else begin
               neg_ff <= opa[WORD_W-1] ^ opb[WORD_W-1];
               dvs_ff <= amag;
               lo_ff  <= DIVD_W'(bmag);
            end
         end else if (busy_ff) begin
            if (div_ff) begin
               hi_ff <= dge ? (dtry - {1'b0, dvs_ff}) : dtry;
               lo_ff <= {lo_ff[DIVD_W-2:0], dge};
            end else begin
               hi_ff <= msum[WORD_W+1:1];
               lo_ff <= {lo_ff[DIVD_W-1:WORD_W], msum[0], lo_ff[WORD_W-1:1]};
            end
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == last) begin
               busy_ff <= 1'b0;
               post_ff <= 1'b1;
            end
         end else if (post_ff) begin
            post_ff <= 1'b0;
            done_ff <= 1'b1;
            if (div_ff) begin
               result_ff <= RES_W'(quot_s);
            end else begin
               result_ff <= RES_W'(prod_s >>> FRAC_BITS);
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

[sv/altitude_kalman_filter.sv]
// Three-state altitude Kalman filter, sequenced over one shared bit-serial unit.
// One tick is worked at a time. Synchronous active-high reset restores the
// register defaults, zeroes the state vector and sets the covariance to
// identity at once.
`default_nettype none

module altitude_kalman_filter import akf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   akf_req_if.sink               req_chan,
   akf_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // The sequencer walks a fixed program. Each step fetches up to three operands
   // from the scratch memory or the fixed sources, runs one serial multiply or
   // divide, adds it to a base value and stores the sum as its write mode says.
   typedef enum logic [3:0] {
      S_IDLE, S_FA, S_FB, S_FC, S_GO, S_WAIT, S_ADD, S_WRITE, S_DONE
   } state_type;

   localparam logic signed [ACC_W-1:0] S32_MAX = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] S32_MIN = ACC_W'(-64'sd2147483648);
   localparam logic signed [ACC_W-1:0] S25_MAX = ACC_W'(64'sd16777215);
   localparam logic signed [ACC_W-1:0] S25_MIN = ACC_W'(-64'sd16777216);
   localparam logic signed [STATE_W-1:0] S24_MAX = STATE_W'(8388607);
   localparam logic signed [STATE_W-1:0] S24_MIN = STATE_W'(-8388608);
   localparam logic signed [WORD_W-1:0] ONE_Q  = WORD_W'(1) <<< FRAC_BITS;
   localparam logic signed [WORD_W-1:0] HALF_Q = WORD_W'(1) <<< (FRAC_BITS - 1);

   state_type state_ff;
   logic [PC_W-1:0] pc_ff;
   instr_type instr;

   // Configuration registers.
   logic [STEP_W-1:0]  step_time_ff;
   logic [NOISE_W-1:0] vel_noise_ff, bias_noise_ff, range_noise_ff, gravity_ff;

   // Latched input tick.
   logic signed [ACCEL_W-1:0] accel_ff;
   logic                      rv_ff;
   logic [MM_W-1:0]           mm_ff;
   logic [TILT_W-1:0]         tc_ff;

   // Scratch memory holding the state, covariance and temporaries. Slots that
   // were never written since reset read as their reset value.
   logic signed [WORD_W-1:0] mem [2**MEM_AW];
   logic [2**MEM_AW-1:0]     mem_valid_ff;
   logic signed [WORD_W-1:0] mem_q_ff;
   logic                     rd_valid_ff;
   src_type                  rd_addr, rd_sel_ff;
   logic                     mem_we;
   logic signed [WORD_W-1:0] wdata;
   logic                     wclip;

   logic signed [WORD_W-1:0] pick_val, opa_ff, opb_ff, opc_ff;
   logic signed [ACC_W-1:0]  acc_ff, base, term;
   logic                     unit_done;
   logic signed [RES_W-1:0]  unit_res;
   akf_ctl_type              unit_ctl;
   logic                     fin;

   // Per-tick flags and mirrors of the outputs.
   logic                       sat_ff, corr_ff;
   logic signed [STATE_W-1:0]  y_ff, x0_ff, x1_ff, x2_ff;
   logic signed [ACCEL_W-1:0]  u_ff;
   logic signed [MEAS_W-1:0]   ym;
   logic                       ym_clip;

   logic                       rsp_valid_ff;
   logic signed [STATE_W-1:0]  alt_out_ff, vel_out_ff, bias_out_ff;
   logic signed [MEAS_W-1:0]   meas_out_ff;
   logic signed [ACCEL_W-1:0]  net_out_ff;
   logic                       corr_out_ff, sat_out_ff;

   assign instr = prog_rom(pc_ff);

   always_comb begin
      case (state_ff)
         S_FA:    rd_addr = instr.a_sel;
         S_FB:    rd_addr = instr.b_sel;
         S_FC:    rd_addr = instr.c_sel;
         default: rd_addr = instr.a_sel;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[instr.dst[MEM_AW-1:0]] <= wdata;
      end
      mem_q_ff    <= mem[rd_addr[MEM_AW-1:0]];
      rd_valid_ff <= mem_valid_ff[rd_addr[MEM_AW-1:0]];
      rd_sel_ff   <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_valid_ff <= '0;
      end else if (mem_we) begin
         mem_valid_ff[instr.dst[MEM_AW-1:0]] <= 1'b1;
      end
   end

   // Operand selection for the word read in the previous cycle.
   always_comb begin
      case (rd_sel_ff)
         SRC_ZERO:  pick_val = '0;
         SRC_ONE:   pick_val = ONE_Q;
         SRC_HALF:  pick_val = HALF_Q;
         SRC_DT:    pick_val = WORD_W'(step_time_ff);
         SRC_VN:    pick_val = WORD_W'(vel_noise_ff);
         SRC_BN:    pick_val = WORD_W'(bias_noise_ff);
         SRC_RN:    pick_val = WORD_W'(range_noise_ff);
         SRC_G:     pick_val = WORD_W'(gravity_ff);
         SRC_ACC:   pick_val = WORD_W'(accel_ff);
         SRC_MM:    pick_val = WORD_W'(mm_ff);
         SRC_TC:    pick_val = WORD_W'(tc_ff);
         SRC_K1000: pick_val = MM_PER_M;
         default: begin
            if (rd_valid_ff) begin
               pick_val = mem_q_ff;
            end else if (rd_sel_ff == SRC_P00 || rd_sel_ff == SRC_P11 ||
                         rd_sel_ff == SRC_P22) begin
               pick_val = ONE_Q;
            end else begin
               pick_val = '0;
            end
         end
      endcase
   end

   assign unit_ctl.start  = (state_ff == S_GO);
   assign unit_ctl.is_div = (instr.op == OP_DIV);

   akf_serial_unit u_serial (
      .clock  (clock),
      .reset  (reset),
      .ctl    (unit_ctl),
      .opa    (opa_ff),
      .opb    (opb_ff),
      .done   (unit_done),
      .result (unit_res)
   );

   always_comb begin
      base = instr.chain ? acc_ff : ACC_W'(opc_ff);
      term = instr.neg ? -ACC_W'(unit_res) : ACC_W'(unit_res);
   end

   // Saturation of the accumulated sum on write-back.
   always_comb begin
      wclip = 1'b0;
      wdata = acc_ff[WORD_W-1:0];
      case (instr.wmode)
         WM_SAT32: begin
            if (acc_ff > S32_MAX) begin
               wclip = 1'b1;
               wdata = WORD_W'(S32_MAX);
            end else if (acc_ff < S32_MIN) begin
               wclip = 1'b1;
               wdata = WORD_W'(S32_MIN);
            end
         end
         WM_SAT25: begin
            if (acc_ff > S25_MAX) begin
               wclip = 1'b1;
               wdata = WORD_W'(S25_MAX);
            end else if (acc_ff < S25_MIN) begin
               wclip = 1'b1;
               wdata = WORD_W'(S25_MIN);
            end
         end
         default: wclip = 1'b0;
      endcase
      mem_we = (state_ff == S_WRITE) && (instr.wmode != WM_NONE);
   end

   // End of program: always at the last step, after the prediction when no
   // range sample came, and before the gains when the innovation variance is
   // not positive.
   always_comb begin
      case (instr.br)
         BR_NOVALID: fin = !rv_ff;
         BR_NOPOS:   fin = (acc_ff <= ACC_W'(0));
         BR_END:     fin = 1'b1;
         default:    fin = 1'b0;
      endcase
   end

   // The reported measurement is clipped to its narrower field.
   always_comb begin
      ym_clip = 1'b0;
      ym      = y_ff[MEAS_W-1:0];
      if (y_ff > S24_MAX) begin
         ym_clip = 1'b1;
         ym      = S24_MAX[MEAS_W-1:0];
      end else if (y_ff < S24_MIN) begin
         ym_clip = 1'b1;
         ym      = S24_MIN[MEAS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         pc_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
         step_time_ff   <= STEP_RST;
         vel_noise_ff   <= VNOISE_RST;
         bias_noise_ff  <= BNOISE_RST;
         range_noise_ff <= RNOISE_RST;
         gravity_ff     <= GRAVITY_RST;
         x0_ff          <= '0;
         x1_ff          <= '0;
         x2_ff          <= '0;
         sat_ff         <= 1'b0;
         corr_ff        <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_STEP_TIME:   step_time_ff   <= csr_wdata[STEP_W-1:0];
               CSR_VEL_NOISE:   vel_noise_ff   <= csr_wdata;
               CSR_BIAS_NOISE:  bias_noise_ff  <= csr_wdata;
               CSR_RANGE_NOISE: range_noise_ff <= csr_wdata;
               CSR_GRAVITY:     gravity_ff     <= csr_wdata;
               default:         ;
            endcase
         end

         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  accel_ff <= req_chan.vertical_accel;
                  rv_ff    <= req_chan.range_valid;
                  mm_ff    <= req_chan.range_mm;
                  tc_ff    <= req_chan.tilt_cosine;
                  pc_ff    <= '0;
                  sat_ff   <= 1'b0;
                  corr_ff  <= 1'b0;
                  y_ff     <= '0;
                  state_ff <= S_FA;
               end
            end
            S_FA: state_ff <= S_FB;
            S_FB: begin
               opa_ff   <= pick_val;
               state_ff <= S_FC;
            end
            S_FC: begin
               opb_ff   <= pick_val;
               state_ff <= S_GO;
            end
            S_GO: begin
               opc_ff   <= pick_val;
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (unit_done) begin
                  state_ff <= S_ADD;
               end
            end
            S_ADD: begin
               acc_ff   <= base + term;
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               if (wclip) begin
                  sat_ff <= 1'b1;
               end
               if (mem_we) begin
                  case (instr.dst)
                     SRC_X0:  x0_ff <= wdata[STATE_W-1:0];
                     SRC_X1:  x1_ff <= wdata[STATE_W-1:0];
                     SRC_X2:  x2_ff <= wdata[STATE_W-1:0];
                     SRC_Y:   y_ff  <= wdata[STATE_W-1:0];
                     SRC_U:   u_ff  <= wdata[ACCEL_W-1:0];
                     default: ;
                  endcase
               end
               if (instr.br == BR_NOPOS && !fin) begin
                  corr_ff <= 1'b1;
               end
               pc_ff    <= pc_ff + PC_W'(1);
               state_ff <= fin ? S_DONE : S_FA;
            end
            S_DONE: begin
               // Hold the finished tick until the output register is free.
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  alt_out_ff   <= x0_ff;
                  vel_out_ff   <= x1_ff;
                  bias_out_ff  <= x2_ff;
                  meas_out_ff  <= ym;
                  net_out_ff   <= u_ff;
                  corr_out_ff  <= corr_ff;
                  sat_out_ff   <= sat_ff | ym_clip;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_chan.ready             = (state_ff == S_IDLE);
   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.altitude          = alt_out_ff;
   assign rsp_chan.vertical_velocity = vel_out_ff;
   assign rsp_chan.accel_bias        = bias_out_ff;
   assign rsp_chan.measured_altitude = meas_out_ff;
   assign rsp_chan.net_accel         = net_out_ff;
   assign rsp_chan.corrected         = corr_out_ff;
   assign rsp_chan.saturated         = sat_out_ff;

endmodule

`default_nettype wire
